FILE: design/ppl1d_pkg.sv
// Shared types and constants for the 1-D leapfrog particle pusher.
`timescale 1ns / 1ps
package ppl1d_pkg;

    // Field widths of the command and result beats
    localparam int OP_W       = 2;
    localparam int NODE_W     = 11;
    localparam int FIELD_W    = 32;
    localparam int POS_W      = 26;
    localparam int VEL_W      = 32;
    localparam int CELLS_W    = 11;
    localparam int LEN_W      = POS_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_VEL_COEFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_COEFF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_USE = 2'd2;

    localparam logic signed [31:0] VEL_COEFF_RST    = 32'sd65536;
    localparam logic [31:0]        POS_COEFF_RST    = 32'd65536;
    localparam logic [CELLS_W-1:0] CELLS_IN_USE_RST = 11'd1024;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
    localparam logic [OP_W-1:0] OP_REWIND = 2'd2;

    // Velocity kick rounding: full step for push, half step for rewind
    localparam int KICK_SHIFT_PUSH   = 16;
    localparam int KICK_SHIFT_REWIND = 17;

    // Particle traveling down the pipe
    typedef struct packed {
        logic                    valid;
        logic                    is_push;
        logic [POS_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
    } item_t;

    // Finished result ahead of the output register
    typedef struct packed {
        logic                    valid;
        logic [POS_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
        logic                    skip;
    } result_t;

endpackage

FILE: design/ppl1d_chan_if.sv
// Valid/ready channel interfaces for command and result beats.
`timescale 1ns / 1ps
interface ppl1d_cmd_if;
    import ppl1d_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [NODE_W-1:0]         node_index;
    logic signed [FIELD_W-1:0] field_value;
    logic [POS_W-1:0]          position_in;
    logic signed [VEL_W-1:0]   velocity_in;

    modport source (
        output valid, operation, node_index, field_value, position_in, velocity_in,
        input  ready
    );
    modport sink (
        input  valid, operation, node_index, field_value, position_in, velocity_in,
        output ready
    );
endinterface

interface ppl1d_res_if;
    import ppl1d_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        position_out;
    logic signed [VEL_W-1:0] velocity_out;
    logic                    cell_skip;

    modport source (
        output valid, position_out, velocity_out, cell_skip,
        input  ready
    );
    modport sink (
        input  valid, position_out, velocity_out, cell_skip,
        output ready
    );
endinterface

FILE: design/ppl1d_field_mem.sv
// Field grid memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module ppl1d_field_mem #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [31:0]   wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr_a,
    input  logic [AW-1:0]        raddr_b,
    output logic signed [31:0]   rdata_a,
    output logic signed [31:0]   rdata_b
);
    logic signed [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: design/ppl1d_gather.sv
// Linear field interpolation: E = f0 + (f1 - f0) * d, rounded.
`timescale 1ns / 1ps
module ppl1d_gather #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  ppl1d_pkg::item_t         item,
    input  logic [POS_FRAC_BITS-1:0] frac,
    input  logic signed [31:0]       node_lo,
    input  logic signed [31:0]       node_hi,
    output ppl1d_pkg::item_t         item_out,
    output logic signed [31:0]       field_e
);
    import ppl1d_pkg::*;

    localparam int PROD_W = 34 + POS_FRAC_BITS;
    localparam int ACC_W  = 35 + POS_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (POS_FRAC_BITS - 1);

    item_t                     item_a_reg, item_b_reg, item_c_reg;
    logic signed [32:0]        diff_reg;
    logic signed [31:0]        f0_a_reg, f0_b_reg;
    logic [POS_FRAC_BITS-1:0]  frac_a_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_next, acc_shift;
    logic signed [31:0]        e_reg;

    always_comb
    begin
        prod_next = diff_reg * signed'({1'b0, frac_a_reg});
        acc_next  = (ACC_W'(f0_b_reg) <<< POS_FRAC_BITS) + ACC_W'(prod_reg) + ACC_HALF;
        acc_shift = acc_next >>> POS_FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_a_reg <= '0;
            item_b_reg <= '0;
            item_c_reg <= '0;
        end
        else if (en)
        begin
            item_a_reg <= item;
            item_b_reg <= item_a_reg;
            item_c_reg <= item_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg   <= 33'(node_hi) - 33'(node_lo);
            f0_a_reg   <= node_lo;
            frac_a_reg <= frac;
            prod_reg   <= prod_next;
            f0_b_reg   <= f0_a_reg;
            e_reg      <= acc_shift[31:0];
        end
    end

    assign item_out = item_c_reg;
    assign field_e  = e_reg;

endmodule

FILE: design/ppl1d_push.sv
// Velocity kick, position advance, periodic wrap and clamp.
`timescale 1ns / 1ps
module ppl1d_push #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  ppl1d_pkg::item_t            item,
    input  logic signed [31:0]          field_e,
    input  logic signed [31:0]          vel_coeff,
    input  logic [31:0]                 pos_coeff,
    input  logic [ppl1d_pkg::LEN_W-1:0] domain_len,
    output ppl1d_pkg::result_t          result
);
    import ppl1d_pkg::*;

    localparam int K_W   = 48;
    localparam int VS_W  = 49;
    localparam int DP_W  = 33 + POS_FRAC_BITS;
    localparam int NP_W  = DP_W + 1;
    localparam int DP_SH = 32 - POS_FRAC_BITS;

    localparam logic signed [63:0] HALF_PUSH   = 64'(1) << (KICK_SHIFT_PUSH - 1);
    localparam logic signed [63:0] HALF_REWIND = 64'(1) << (KICK_SHIFT_REWIND - 1);
    localparam logic signed [VS_W-1:0] VS_MAX  = VS_W'(32'sh7fffffff);
    localparam logic signed [VS_W-1:0] VS_MIN  = VS_W'(32'sh80000000);
    localparam logic signed [64:0] DP_HALF     = 65'(1) << (DP_SH - 1);
    localparam logic signed [DP_W-1:0] ONE_CELL     = DP_W'(1) << POS_FRAC_BITS;
    localparam logic signed [DP_W-1:0] NEG_ONE_CELL = -ONE_CELL;

    item_t                   item_k1_reg, item_k2_reg, item_k3_reg;
    item_t                   item_a1_reg, item_a2_reg, item_a3_reg, item_a4_reg;
    logic signed [63:0]      kprod_reg, ksum, kshift;
    logic signed [K_W-1:0]   kick_reg;
    logic signed [VS_W-1:0]  vsum;
    logic signed [VEL_W-1:0] vsat;
    logic signed [64:0]      dprod_reg, dprod_next, dsum, dshift;
    logic signed [DP_W-1:0]  dp_reg;
    logic signed [NP_W-1:0]  np_reg, np_next, len_ext, wrap_reg, wrap_next, clamp;
    logic                    skip_a3_reg, skip_a4_reg, skip_next;
    item_t                   item_k3_next;

    // kick: rounded shift of vel_coeff * E, then saturating add or subtract
    always_comb
    begin
        ksum   = kprod_reg + (item_k1_reg.is_push ? HALF_PUSH : HALF_REWIND);
        kshift = item_k1_reg.is_push ? (ksum >>> KICK_SHIFT_PUSH)
                                     : (ksum >>> KICK_SHIFT_REWIND);

        if (item_k2_reg.is_push)
        begin
            vsum = VS_W'($signed(item_k2_reg.vel)) + VS_W'(kick_reg);
        end
        else
        begin
            vsum = VS_W'($signed(item_k2_reg.vel)) - VS_W'(kick_reg);
        end

        if (vsum > VS_MAX)
        begin
            vsat = 32'sh7fffffff;
        end
        else if (vsum < VS_MIN)
        begin
            vsat = 32'sh80000000;
        end
        else
        begin
            vsat = vsum[VEL_W-1:0];
        end

        item_k3_next     = item_k2_reg;
        item_k3_next.vel = vsat;
    end

    // advance: rounded pos_coeff * v, then add, wrap once, clamp
    always_comb
    begin
        dprod_next = $signed({1'b0, pos_coeff}) * $signed(item_k3_reg.vel);
        dsum       = dprod_reg + DP_HALF;
        dshift     = dsum >>> DP_SH;

        np_next    = NP_W'($signed({1'b0, item_a2_reg.pos})) + NP_W'(dp_reg);
        skip_next  = (dp_reg > ONE_CELL) || (dp_reg < NEG_ONE_CELL);

        len_ext    = NP_W'($signed({1'b0, domain_len}));
        if (np_reg < 0)
        begin
            wrap_next = np_reg + len_ext;
        end
        else if (np_reg >= len_ext)
        begin
            wrap_next = np_reg - len_ext;
        end
        else
        begin
            wrap_next = np_reg;
        end

        if (wrap_reg < 0)
        begin
            clamp = '0;
        end
        else if (wrap_reg >= len_ext)
        begin
            clamp = len_ext - NP_W'(1);
        end
        else
        begin
            clamp = wrap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_k1_reg <= '0;
            item_k2_reg <= '0;
            item_k3_reg <= '0;
            item_a1_reg <= '0;
            item_a2_reg <= '0;
            item_a3_reg <= '0;
            item_a4_reg <= '0;
        end
        else if (en)
        begin
            item_k1_reg <= item;
            item_k2_reg <= item_k1_reg;
            item_k3_reg <= item_k3_next;
            item_a1_reg <= item_k3_reg;
            item_a2_reg <= item_a1_reg;
            item_a3_reg <= item_a2_reg;
            item_a4_reg <= item_a3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kprod_reg   <= vel_coeff * field_e;
            kick_reg    <= kshift[K_W-1:0];
            dprod_reg   <= dprod_next;
            dp_reg      <= dshift[DP_W-1:0];
            np_reg      <= np_next;
            skip_a3_reg <= skip_next;
            wrap_reg    <= wrap_next;
            skip_a4_reg <= skip_a3_reg;
        end
    end

    always_comb
    begin
        result.valid = item_a4_reg.valid;
        result.vel   = item_a4_reg.vel;
        if (item_a4_reg.is_push)
        begin
            result.pos  = clamp[POS_W-1:0];
            result.skip = skip_a4_reg;
        end
        else
        begin
            result.pos  = item_a4_reg.pos;
            result.skip = 1'b0;
        end
    end

endmodule

FILE: design/particle_push_leapfrog_1d_unit.sv
// Top level of the 1-D periodic leapfrog particle pusher.
`timescale 1ns / 1ps
//
//  Channel  Dir  Beat payload                                          Beat taken when
//  -------  ---  ----------------------------------------------------  ---------------------
//  cmd      in   operation, node_index, field_value, position_in,      cmd.valid & cmd.ready
//                velocity_in
//  res      out  position_out, velocity_out, cell_skip                 res.valid & res.ready
//  cfg      in   cfg_index, cfg_data (vel_coeff, pos_coeff,            cfg_we
//                cells_in_use)
//
//  One command beat per cycle while the pipe does not stall. A push or rewind result
//  passes gather and push to the output register; loads and code 3 give no result beat.
//  The pipe is one chain with a shared enable: it stalls only while the output
//  register holds a beat that res.ready does not take, and cmd.ready follows that.
//  The field grid sits in a two-read-port memory, read at the command beat;
//  a load writes at its own beat, so a later push always sees it.
//  Reset clears control and resets the configuration; the grid is not cleared.
//
module particle_push_leapfrog_1d_unit #(
    parameter int MAX_CELLS     = 1024,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ppl1d_cmd_if.sink                        cmd,
    ppl1d_res_if.source                      res,
    input  logic                             cfg_we,
    input  logic [ppl1d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppl1d_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppl1d_pkg::*;

    localparam int DEPTH      = MAX_CELLS + 1;
    localparam int AW         = $clog2(DEPTH);
    // domain can never exceed what the integer part of a position holds
    localparam int TOP_CELLS  = 1 << (POS_W - POS_FRAC_BITS);
    localparam int CAP_CELLS  = (MAX_CELLS < TOP_CELLS) ? MAX_CELLS : TOP_CELLS;

    // ---------------- configuration ----------------
    logic signed [31:0]   vel_coeff_reg;
    logic [31:0]          pos_coeff_reg;
    logic [CELLS_W-1:0]   cells_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_coeff_reg    <= VEL_COEFF_RST;
            pos_coeff_reg    <= POS_COEFF_RST;
            cells_in_use_reg <= CELLS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VEL_COEFF:    vel_coeff_reg    <= signed'(cfg_data);
                CFG_POS_COEFF:    pos_coeff_reg    <= cfg_data;
                CFG_CELLS_IN_USE: cells_in_use_reg <= cfg_data[CELLS_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective cell count, clamped to 1..CAP_CELLS; domain length in position LSBs
    logic [31:0]      eff_cells;
    logic [LEN_W-1:0] domain_len;

    always_comb
    begin
        if (cells_in_use_reg == '0)
        begin
            eff_cells = 32'd1;
        end
        else if (32'(cells_in_use_reg) > 32'(CAP_CELLS))
        begin
            eff_cells = 32'(CAP_CELLS);
        end
        else
        begin
            eff_cells = 32'(cells_in_use_reg);
        end
        domain_len = LEN_W'(eff_cells) << POS_FRAC_BITS;
    end

    // ---------------- handshake / stall ----------------
    logic    res_valid_reg;
    logic    pipe_en;
    logic    cmd_accept;

    assign pipe_en    = !res_valid_reg || res.ready;
    assign cmd.ready  = pipe_en;
    assign cmd_accept = cmd.valid && pipe_en;

    // ---------------- command stage: grid addresses ----------------
    logic [POS_W-1:0]         pos_clip;
    logic [31:0]              cell_idx, cell_nxt, node_ext;
    logic [AW-1:0]            raddr_a, raddr_b, waddr;
    logic [POS_FRAC_BITS-1:0] frac;
    logic                     load_we;
    item_t                    item_s0;

    always_comb
    begin
        // gather uses a position just inside the domain if the input is past its end
        if (LEN_W'(cmd.position_in) < domain_len)
        begin
            pos_clip = cmd.position_in;
        end
        else
        begin
            pos_clip = POS_W'(domain_len - LEN_W'(1));
        end
        cell_idx = 32'(pos_clip[POS_W-1:POS_FRAC_BITS]);
        cell_nxt = cell_idx + 32'd1;
        frac     = pos_clip[POS_FRAC_BITS-1:0];
        raddr_a  = cell_idx[AW-1:0];
        raddr_b  = cell_nxt[AW-1:0];

        node_ext = 32'(cmd.node_index);
        waddr    = node_ext[AW-1:0];
        load_we  = cmd_accept && (cmd.operation == OP_LOAD)
                   && (node_ext <= 32'(MAX_CELLS));

        item_s0.valid   = cmd_accept
                          && ((cmd.operation == OP_PUSH) || (cmd.operation == OP_REWIND));
        item_s0.is_push = (cmd.operation == OP_PUSH);
        item_s0.pos     = cmd.position_in;
        item_s0.vel     = cmd.velocity_in;
    end

    // ---------------- grid memory ----------------
    logic signed [31:0] node_lo, node_hi;

    ppl1d_field_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_field_mem (
        .clk     (clk),
        .we      (load_we),
        .waddr   (waddr),
        .wdata   (cmd.field_value),
        .re      (pipe_en),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (node_lo),
        .rdata_b (node_hi)
    );

    // item and fraction line up with the registered read data
    item_t                    item_s1_reg;
    logic [POS_FRAC_BITS-1:0] frac_s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_s1_reg <= '0;
        end
        else if (pipe_en)
        begin
            item_s1_reg <= item_s0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            frac_s1_reg <= frac;
        end
    end

    // ---------------- gather ----------------
    item_t              item_g;
    logic signed [31:0] field_e;

    ppl1d_gather #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_gather (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .item     (item_s1_reg),
        .frac     (frac_s1_reg),
        .node_lo  (node_lo),
        .node_hi  (node_hi),
        .item_out (item_g),
        .field_e  (field_e)
    );

    // ---------------- kick and advance ----------------
    result_t result;

    ppl1d_push #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_push (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .item       (item_g),
        .field_e    (field_e),
        .vel_coeff  (vel_coeff_reg),
        .pos_coeff  (pos_coeff_reg),
        .domain_len (domain_len),
        .result     (result)
    );

    // ---------------- output register ----------------
    logic [POS_W-1:0]        pos_out_reg;
    logic signed [VEL_W-1:0] vel_out_reg;
    logic                    skip_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            res_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pos_out_reg  <= result.pos;
            vel_out_reg  <= result.vel;
            skip_out_reg <= result.skip;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.position_out = pos_out_reg;
    assign res.velocity_out = vel_out_reg;
    assign res.cell_skip    = skip_out_reg;

endmodule
